>>> src/assert_macros.svh
// Assertion macros for the Q24.8 fixed-point unit.
// No dependencies; included by RTL files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FPA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define FPA_ASSERT(lbl, clk, rst_n, prop)
`define FPA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> src/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point unit.
// No dependencies.
`default_nettype none

package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;
  // quotient bits resolved per divider stage
  localparam int STEP_BITS     = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // side data riding along the divider pipeline
  typedef struct packed {
    op_e               op;
    logic              neg;    // quotient sign
    logic              err;    // divide by zero
    logic [DATA_W-1:0] early;  // add/sub/mul result
  } side_t;

endpackage

`default_nettype wire

>>> src/fpa_front.sv
// First pipeline stage: add, subtract, multiply and divider operand prep.
// Depends on fpa_pkg.
`default_nettype none

module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int NUM_W     = 40
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a_i,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b_i,
  output logic                                 valid_o,
  output fpa_pkg::side_t                       side_o,
  output logic [NUM_W-1:0]                     num_o,
  output logic [fpa_pkg::DATA_W-1:0]           den_o
);

  localparam int W = fpa_pkg::DATA_W;

  fpa_pkg::op_e              op;
  logic signed [2*W-1:0]     prod;
  logic [W-1:0]              mag_a, mag_b;
  logic                      valid_q;
  fpa_pkg::side_t            side_d, side_q;
  logic [NUM_W-1:0]          num_d, num_q;
  logic [W-1:0]              den_q;

  always_comb begin
    op    = fpa_pkg::op_e'(req_type_i);
    prod  = operand_a_i * operand_b_i;
    mag_a = operand_a_i[W-1] ? (~operand_a_i + 1'b1) : operand_a_i;
    mag_b = operand_b_i[W-1] ? (~operand_b_i + 1'b1) : operand_b_i;
    num_d = NUM_W'(mag_a) << FRAC_BITS;

    side_d.op  = op;
    side_d.neg = operand_a_i[W-1] ^ operand_b_i[W-1];
    side_d.err = (op == fpa_pkg::OP_DIV) && (operand_b_i == '0);
    case (op)
      fpa_pkg::OP_ADD: side_d.early = operand_a_i + operand_b_i;
      fpa_pkg::OP_SUB: side_d.early = operand_a_i - operand_b_i;
      fpa_pkg::OP_MUL: side_d.early = prod[FRAC_BITS+W-1:FRAC_BITS];
      default:         side_d.early = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    num_q  <= num_d;
    den_q  <= mag_b;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

>>> src/fpa_div_stage.sv
// One stage of the pipelined restoring divider, STEP_BITS quotient bits.
// Depends on fpa_pkg.
`default_nettype none

module fpa_div_stage #(
  parameter int NUM_W = 40
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire fpa_pkg::side_t                side_i,
  input  wire logic [NUM_W-1:0]              num_i,
  input  wire logic [fpa_pkg::DATA_W-1:0]    rem_i,
  input  wire logic [fpa_pkg::DATA_W-1:0]    quo_i,
  input  wire logic [fpa_pkg::DATA_W-1:0]    den_i,
  output logic                               valid_o,
  output fpa_pkg::side_t                     side_o,
  output logic [NUM_W-1:0]                   num_o,
  output logic [fpa_pkg::DATA_W-1:0]         rem_o,
  output logic [fpa_pkg::DATA_W-1:0]         quo_o,
  output logic [fpa_pkg::DATA_W-1:0]         den_o
);

  localparam int W = fpa_pkg::DATA_W;

  logic [W:0]       trial;
  logic             qbit;
  logic [NUM_W-1:0] num_d, num_q;
  logic [W-1:0]     rem_d, rem_q, quo_d, quo_q, den_q;
  logic             valid_q;
  fpa_pkg::side_t   side_q;

  always_comb begin
    trial = '0;
    qbit  = 1'b0;
    num_d = num_i;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int i = 0; i < fpa_pkg::STEP_BITS; i++) begin
      trial = {rem_d, num_d[NUM_W-1]};
      num_d = num_d << 1;
      qbit  = (trial >= {1'b0, den_i});
      if (qbit) begin
        trial = trial - {1'b0, den_i};
      end
      rem_d = trial[W-1:0];
      quo_d = {quo_d[W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_i;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

>>> src/fpa_back.sv
// Last pipeline stage: quotient sign fix-up, result select, output registers.
// Depends on fpa_pkg.
`default_nettype none

module fpa_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire fpa_pkg::side_t                      side_i,
  input  wire logic [fpa_pkg::DATA_W-1:0]          quo_i,
  output logic                                     done_o,
  output logic signed [fpa_pkg::DATA_W-1:0]        result_value_o,
  output logic                                     divide_error_o
);

  localparam int W = fpa_pkg::DATA_W;

  logic [W-1:0] res_d, res_q;
  logic         done_q, err_q;

  always_comb begin
    if (side_i.op != fpa_pkg::OP_DIV) begin
      res_d = side_i.early;
    end else if (side_i.err) begin
      res_d = '0;
    end else if (side_i.neg) begin
      res_d = ~quo_i + 1'b1;
    end else begin
      res_d = quo_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    err_q <= side_i.err;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign divide_error_o = err_q;

endmodule

`default_nettype wire

>>> src/fixed_point_q24_8_alu.sv
// Top level of the Q24.8 fixed-point arithmetic unit.
// Depends on fpa_pkg, fpa_front, fpa_div_stage, fpa_back, assert_macros.svh.
//
// Usage:
//  - A transaction is accepted at a rising edge with start high and busy low.
//    busy is always low: the pipeline never stalls, so one transaction can be
//    issued every cycle.
//  - req_type_i selects add, subtract, multiply or divide on two raw signed
//    values with FRAC_BITS fractional bits; results wrap to 32 bits.
//  - Each result shows for exactly one cycle with done_o high, in issue
//    order. The receiver cannot stall and nothing is buffered.
//  - The pipeline is one front stage (add/sub, 32x32 multiply, operand
//    magnitudes), a restoring divider resolving two quotient bits per stage,
//    and one output stage. All operations pass through the same stages.
//  - Throughput: one transaction per cycle.
//  - Divide by zero returns 0 with divide_error_o set.
//  - Reset clears the valid bits only; in-flight transactions are dropped.
`default_nettype none
`include "assert_macros.svh"

module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          req_type_i,
  input  wire logic signed [fpa_pkg::DATA_W-1:0]   operand_a_i,
  input  wire logic signed [fpa_pkg::DATA_W-1:0]   operand_b_i,
  output logic                                     done_o,
  output logic signed [fpa_pkg::DATA_W-1:0]        result_value_o,
  output logic                                     divide_error_o
);

  localparam int W          = fpa_pkg::DATA_W;
  // divider stages; the scaled dividend magnitude needs W + FRAC_BITS bits
  localparam int DIV_STAGES = (W + FRAC_BITS + fpa_pkg::STEP_BITS - 1) / fpa_pkg::STEP_BITS;
  localparam int NUM_W      = DIV_STAGES * fpa_pkg::STEP_BITS;
  localparam int LATENCY    = DIV_STAGES + 2;

  // pipeline taps, index 0 is the front stage output
  logic           vld   [DIV_STAGES+1];
  fpa_pkg::side_t side  [DIV_STAGES+1];
  logic [NUM_W-1:0] num [DIV_STAGES+1];
  logic [W-1:0]   rem   [DIV_STAGES+1];
  logic [W-1:0]   quo   [DIV_STAGES+1];
  logic [W-1:0]   den   [DIV_STAGES+1];
  logic           accept;
  logic           div0_req;

  // never back-pressures
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // divide request with a zero divisor at the input
  assign div0_req = (req_type_i == fpa_pkg::OP_DIV) && (operand_b_i == '0);

  fpa_front #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .req_type_i  (req_type_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (vld[0]),
    .side_o      (side[0]),
    .num_o       (num[0]),
    .den_o       (den[0])
  );

  // partial remainder and quotient start at zero
  assign rem[0] = '0;
  assign quo[0] = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    fpa_div_stage #(
      .NUM_W (NUM_W)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[s]),
      .side_i  (side[s]),
      .num_i   (num[s]),
      .rem_i   (rem[s]),
      .quo_i   (quo[s]),
      .den_i   (den[s]),
      .valid_o (vld[s+1]),
      .side_o  (side[s+1]),
      .num_o   (num[s+1]),
      .rem_o   (rem[s+1]),
      .quo_o   (quo[s+1]),
      .den_o   (den[s+1])
    );
  end

  // quotient holds the low W bits of |a| * 2^FRAC_BITS / |b|
  fpa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (vld[DIV_STAGES]),
    .side_i         (side[DIV_STAGES]),
    .quo_i          (quo[DIV_STAGES]),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .divide_error_o (divide_error_o)
  );

  // every accepted transaction comes out with done_o high
  `FPA_ASSERT(a_issue_to_done, clk_i, rst_ni, accept |-> ##LATENCY done_o)
  // no result without an accepted transaction before it
  `FPA_ASSERT(a_done_has_issue, clk_i, rst_ni, done_o |-> $past(accept, LATENCY))
  // divide by zero forces a zero result
  `FPA_ASSERT(a_err_zero, clk_i, rst_ni, (done_o && divide_error_o) |-> (result_value_o == '0))
  // error flag only for a divide with a zero divisor
  `FPA_ASSERT(a_err_cause, clk_i, rst_ni, (done_o && divide_error_o) |-> $past(div0_req, LATENCY))

endmodule

`default_nettype wire
